### rtl/jtp_pkg.sv
// ----------------------------------------------------------------------------
// jtp_pkg
// Shared types, constants and the arctangent step table for joystick_to_polar.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jtp_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ROTATION_STAGES = 14;

    localparam int ZFRAC    = 20;          // fraction bits of the angle accumulator
    localparam int AB_SCALE = 16;          // vector components scaled by 2^16
    localparam int AB_W     = 27;          // vector component width, with gain headroom
    localparam int Z_W      = 30;          // angle accumulator width
    localparam int SH_W     = 5;           // shift amount width, up to 20 stages
    localparam int HEAD_W   = 15;
    localparam int RND_SH   = ZFRAC - ANGLE_FRAC_BITS;

    localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 <<< ZFRAC);
    localparam logic signed [Z_W-1:0] Z_360 = Z_W'(360 <<< ZFRAC);
    localparam logic [Z_W-1:0] RND_HALF  = Z_W'(1 << (RND_SH - 1));
    localparam logic [Z_W-1:0] HEAD_FULL = Z_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [Z_W-1:0] HEAD_HALF = Z_W'(180 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic [7:0] x_position;
        logic [7:0] y_position;
    } jtp_in_t;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [7:0]        strength;
    } jtp_out_t;

    typedef struct packed {
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
        logic signed [Z_W-1:0]  z;
        logic                   axis;     // dx is zero, heading fixed
        logic                   axis_up;  // on the axis and pointing up
        logic [7:0]             strength;
    } jtp_stage_t;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic signed [Z_W-1:0] atan_step(input logic [SH_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(47185920);
            5'd1:    v = Z_W'(27855475);
            5'd2:    v = Z_W'(14718068);
            5'd3:    v = Z_W'(7471121);
            5'd4:    v = Z_W'(3750058);
            5'd5:    v = Z_W'(1876857);
            5'd6:    v = Z_W'(938658);
            5'd7:    v = Z_W'(469357);
            5'd8:    v = Z_W'(234682);
            5'd9:    v = Z_W'(117342);
            5'd10:   v = Z_W'(58671);
            5'd11:   v = Z_W'(29335);
            5'd12:   v = Z_W'(14668);
            5'd13:   v = Z_W'(7334);
            5'd14:   v = Z_W'(3667);
            5'd15:   v = Z_W'(1833);
            5'd16:   v = Z_W'(917);
            5'd17:   v = Z_W'(458);
            5'd18:   v = Z_W'(229);
            5'd19:   v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/jtp_prep.sv
// ----------------------------------------------------------------------------
// jtp_prep
// Front cell: centres the sample, pre-rotates into the right half plane and
// computes the square-boundary strength.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtp_prep (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 up_valid,
    output logic                up_ready,
    input  jtp_pkg::jtp_in_t    up_data,
    output logic                dn_valid,
    input  wire                 dn_ready,
    output jtp_pkg::jtp_stage_t dn_data
);
    import jtp_pkg::*;

    logic       valid_reg;
    jtp_stage_t data_reg;
    jtp_stage_t data_next;

    logic signed [8:0] a_raw;
    logic signed [8:0] b_raw;
    logic signed [8:0] a_rot;
    logic signed [8:0] b_rot;
    logic [7:0]        ax;
    logic [7:0]        ay;
    logic [15:0]       sx_full;
    logic [8:0]        sy;
    logic [8:0]        smax;

    always_comb begin
        a_raw = 9'sd127 - $signed({1'b0, up_data.y_position});
        b_raw = $signed({1'b0, up_data.x_position}) - 9'sd128;

        data_next.z = '0;
        a_rot = a_raw;
        b_rot = b_raw;
        if (a_raw < 0) begin
            if (!b_raw[8]) begin
                a_rot = b_raw;
                b_rot = -a_raw;
                data_next.z = Z_90;
            end else begin
                a_rot = -b_raw;
                b_rot = a_raw;
                data_next.z = -Z_90;
            end
        end
        data_next.a = AB_W'($signed({a_rot, {AB_SCALE{1'b0}}}));
        data_next.b = AB_W'($signed({b_rot, {AB_SCALE{1'b0}}}));
        data_next.axis    = (b_raw == 9'sd0);
        data_next.axis_up = (a_raw > 9'sd0);

        // |dx|*255/128 and |dy|*255/127, the latter as 2|dy| + (|dy| >= 127)
        ax = b_raw[8] ? 8'(-b_raw) : 8'(b_raw);
        ay = a_raw[8] ? 8'(-a_raw) : 8'(a_raw);
        sx_full = {ax, 8'h00} - {8'h00, ax};
        sy = {ay, 1'b0} + {8'h00, (ay >= 8'd127)};
        smax = ({1'b0, sx_full[14:7]} > sy) ? {1'b0, sx_full[14:7]} : sy;
        data_next.strength = smax[8] ? 8'hFF : smax[7:0];
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/jtp_cell.sv
// ----------------------------------------------------------------------------
// jtp_cell
// One vectoring rotation: drives b toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtp_cell (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire [jtp_pkg::SH_W-1:0]   shift_amt,
    input  wire signed [jtp_pkg::Z_W-1:0] angle_step,
    input  wire                       up_valid,
    output logic                      up_ready,
    input  jtp_pkg::jtp_stage_t       up_data,
    output logic                      dn_valid,
    input  wire                       dn_ready,
    output jtp_pkg::jtp_stage_t       dn_data
);
    import jtp_pkg::*;

    logic       valid_reg;
    jtp_stage_t data_reg;
    jtp_stage_t data_next;

    logic signed [AB_W-1:0] a_in;
    logic signed [AB_W-1:0] b_in;
    logic signed [AB_W-1:0] sa;
    logic signed [AB_W-1:0] sb;

    always_comb begin
        a_in = up_data.a;
        b_in = up_data.b;
        sa = a_in >>> shift_amt;   // arithmetic shift floors negatives
        sb = b_in >>> shift_amt;
        data_next = up_data;
        if (!b_in[AB_W-1]) begin
            data_next.a = a_in + sb;
            data_next.b = b_in - sa;
            data_next.z = up_data.z + angle_step;
        end else begin
            data_next.a = a_in - sb;
            data_next.b = b_in + sa;
            data_next.z = up_data.z - angle_step;
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/jtp_finish.sv
// ----------------------------------------------------------------------------
// jtp_finish
// Output cell: wraps the angle into [0, 360), rounds it and holds the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtp_finish (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 up_valid,
    output logic                up_ready,
    input  jtp_pkg::jtp_stage_t up_data,
    output logic                dn_valid,
    input  wire                 dn_ready,
    output jtp_pkg::jtp_out_t   dn_data
);
    import jtp_pkg::*;

    logic     valid_reg;
    jtp_out_t data_reg;
    jtp_out_t data_next;

    logic signed [Z_W-1:0] z_pos;
    logic [Z_W-1:0]        z_rnd;
    logic [Z_W-1:0]        h_full;
    logic [Z_W-1:0]        h_sel;

    always_comb begin
        z_pos  = up_data.z[Z_W-1] ? up_data.z + Z_360 : up_data.z;
        z_rnd  = $unsigned(z_pos) + RND_HALF;
        h_full = z_rnd >> RND_SH;
        if (up_data.axis) begin
            h_sel = up_data.axis_up ? '0 : HEAD_HALF;
        end else if (h_full >= HEAD_FULL) begin
            h_sel = '0;   // rounded up to 360
        end else begin
            h_sel = h_full;
        end
        data_next.heading  = h_sel[HEAD_W-1:0];
        data_next.strength = up_data.strength;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/joystick_to_polar.sv
// ----------------------------------------------------------------------------
// joystick_to_polar
// Stick sample to heading and strength through a chain of rotation cells.
// Each word is registered in the prep cell, every rotation cell and the finish cell.
// Throughput: one word per cycle while the output is not stalled; each cell holds one word and passes it on.
// A stalled output fills bubbles first, so input keeps flowing until full.
// Reset clears all valid flags; no words are held afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module joystick_to_polar (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  jtp_pkg::jtp_in_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output jtp_pkg::jtp_out_t  m_data
);
    import jtp_pkg::*;

    jtp_stage_t stg_data  [ROTATION_STAGES+1];
    logic       stg_valid [ROTATION_STAGES+1];
    logic       stg_ready [ROTATION_STAGES+1];

    jtp_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_data  (s_data),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_data  (stg_data[0])
    );

    for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_cell
        jtp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_amt  (SH_W'(k)),
            .angle_step (atan_step(SH_W'(k))),
            .up_valid   (stg_valid[k]),
            .up_ready   (stg_ready[k]),
            .up_data    (stg_data[k]),
            .dn_valid   (stg_valid[k+1]),
            .dn_ready   (stg_ready[k+1]),
            .dn_data    (stg_data[k+1])
        );
    end

    jtp_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (stg_valid[ROTATION_STAGES]),
        .up_ready (stg_ready[ROTATION_STAGES]),
        .up_data  (stg_data[ROTATION_STAGES]),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_data  (m_data)
    );

endmodule

`default_nettype wire

### rtl/jtp_checker.sv
// ----------------------------------------------------------------------------
// jtp_checker
// Port-level checks for joystick_to_polar, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtp_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input wire               m_valid,
    input wire               m_ready,
    input jtp_pkg::jtp_out_t m_data
);
    import jtp_pkg::*;

    // nothing survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    // a held output word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // an empty output stage means the whole chain can take a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready with empty output");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (Z_W'(m_data.heading) < HEAD_FULL))
        else $error("heading at or beyond 360 degrees");

    // zero strength only at the centre, which points at 180 degrees
    a_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.strength == 8'd0) |-> m_data.heading == HEAD_HALF[HEAD_W-1:0])
        else $error("centre sample heading is not 180 degrees");

endmodule

bind joystick_to_polar jtp_checker u_jtp_checker (.*);

`default_nettype wire

### test/tb_joystick_to_polar.sv
// ----------------------------------------------------------------------------
// tb_joystick_to_polar
// Self-checking bench for the stick-to-polar pipeline. A short table of
// directed samples (axes, corners, centre) runs first, then about a thousand
// random samples. Each output word is compared field by field, in order,
// with a typed-in value or the in-bench CORDIC/strength calculator.
// Bursty input and a patterned output stall exercise the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_to_polar;

    import jtp_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;   // longer than the pipeline depth

    // atan(2^-i) in degrees, 20 fraction bits
    localparam int     Q_ANG = 20;
    localparam longint ATAN_DEG_Q20 [0:19] = '{
        47185920, 27855475, 14718068, 7471121, 3750058,
        1876857, 938658, 469357, 234682, 117342,
        58671, 29335, 14668, 7334, 3667,
        1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [7:0]        x;
        logic [7:0]        y;
        bit                fixed;       // expected value typed in below
        logic [HEAD_W-1:0] heading;
        logic [7:0]        strength;
    } sample_row_t;

    localparam int N_ROWS = 22;
    sample_row_t sample_table [0:N_ROWS-1] = '{
        '{8'd128, 8'd127, 1'b1, 15'd11520, 8'd0},    // centre: 180 deg
        '{8'd128, 8'd0,   1'b1, 15'd0,     8'd255},  // straight up, full
        '{8'd128, 8'd1,   1'b1, 15'd0,     8'd252},
        '{8'd128, 8'd126, 1'b1, 15'd0,     8'd2},
        '{8'd128, 8'd128, 1'b1, 15'd11520, 8'd2},
        '{8'd128, 8'd254, 1'b1, 15'd11520, 8'd255},
        '{8'd128, 8'd255, 1'b1, 15'd11520, 8'd255},  // beyond square, capped
        '{8'd0,   8'd127, 1'b0, 15'd0,     8'd0},
        '{8'd255, 8'd127, 1'b0, 15'd0,     8'd0},
        '{8'd0,   8'd0,   1'b0, 15'd0,     8'd0},
        '{8'd255, 8'd0,   1'b0, 15'd0,     8'd0},
        '{8'd0,   8'd255, 1'b0, 15'd0,     8'd0},
        '{8'd255, 8'd255, 1'b0, 15'd0,     8'd0},
        '{8'd127, 8'd127, 1'b0, 15'd0,     8'd0},
        '{8'd129, 8'd127, 1'b0, 15'd0,     8'd0},
        '{8'd127, 8'd0,   1'b0, 15'd0,     8'd0},    // just left of up, near 360
        '{8'd129, 8'd0,   1'b0, 15'd0,     8'd0},
        '{8'd127, 8'd255, 1'b0, 15'd0,     8'd0},
        '{8'd129, 8'd255, 1'b0, 15'd0,     8'd0},
        '{8'd1,   8'd254, 1'b0, 15'd0,     8'd0},
        '{8'd170, 8'd85,  1'b0, 15'd0,     8'd0},
        '{8'd85,  8'd170, 1'b0, 15'd0,     8'd0}
    };

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    jtp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    jtp_out_t m_data;

    jtp_out_t pending_polar [$];
    int       errors = 0;
    int       burst_left = 0;
    bit       hold_req = 1'b0;

    joystick_to_polar dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // heading of (b, a) = atan2(dx, -dy), CORDIC vectoring, degrees * 2^ANGLE_FRAC_BITS
    function automatic longint heading_of(longint dx, longint dy);
        longint a;
        longint b;
        longint z;
        longint t;
        longint sa;
        longint sb;
        longint h;
        int     sh;
        a  = -dy;
        b  = dx;
        z  = 0;
        sh = Q_ANG - ANGLE_FRAC_BITS;
        if (b == 0)
            return (a > 0) ? 0 : (longint'(180) << ANGLE_FRAC_BITS);
        // pre-rotate into the right half plane
        if (a < 0) begin
            if (b >= 0) begin
                t = a; a = b; b = -t; z = longint'(90) << Q_ANG;
            end else begin
                t = a; a = -b; b = t; z = -(longint'(90) << Q_ANG);
            end
        end
        a = a * 65536;
        b = b * 65536;
        for (int i = 0; i < ROTATION_STAGES && i < 20; i++) begin
            sa = a >>> i;
            sb = b >>> i;
            if (b >= 0) begin
                a = a + sb; b = b - sa; z += ATAN_DEG_Q20[i];
            end else begin
                a = a - sb; b = b + sa; z -= ATAN_DEG_Q20[i];
            end
        end
        if (z < 0)
            z += longint'(360) << Q_ANG;
        h = (z + (longint'(1) << (sh - 1))) >>> sh;
        if (h >= (longint'(360) << ANGLE_FRAC_BITS))
            h = 0;
        return h;
    endfunction

    function automatic jtp_out_t polar_of(jtp_in_t w);
        longint   dx;
        longint   dy;
        longint   sx;
        longint   sy;
        longint   h;
        jtp_out_t r;
        dx = longint'(w.x_position) - 128;
        dy = longint'(w.y_position) - 127;
        h  = heading_of(dx, dy);
        sx = ((dx < 0) ? -dx : dx) * 255 / 128;
        sy = ((dy < 0) ? -dy : dy) * 255 / 127;
        if (sy > sx)
            sx = sy;
        if (sx > 255)
            sx = 255;
        r.heading  = h[HEAD_W-1:0];
        r.strength = sx[7:0];
        return r;
    endfunction

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return 8'd129;
            default: return 8'd1;
        endcase
    endfunction

    function automatic jtp_in_t random_sample();
        jtp_in_t w;
        int      d;
        w.x_position = 8'($urandom);
        w.y_position = 8'($urandom);
        case ($urandom_range(0, 9))
            4: w.x_position = 8'd128;                      // on the vertical axis
            5: w.y_position = 8'd127;                      // on the horizontal axis
            6: begin                                       // near the centre
                w.x_position = 8'($urandom_range(124, 132));
                w.y_position = 8'($urandom_range(123, 131));
            end
            7: begin
                w.x_position = edge_byte();
                w.y_position = edge_byte();
            end
            8: begin                                       // near the diagonals
                d = $urandom_range(0, 127);
                w.x_position = $urandom_range(0, 1) ? 8'(128 + d) : 8'(128 - d);
                w.y_position = $urandom_range(0, 1) ? 8'(127 + d) : 8'(127 - d);
            end
            default: ;
        endcase
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(jtp_in_t w, jtp_out_t want);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
        burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_polar.push_back(want);
        @(negedge aclk);
    endtask

    task automatic note_error(string msg, jtp_out_t want, jtp_out_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected heading %0d strength %0d, got heading %0d strength %0d",
                     $realtime, msg, want.heading, want.strength, got.heading, got.strength);
    endtask

    // output side stall pattern, with an occasional long hold-off on request
    initial begin : rx_stall
        int hold_left;
        int mode;
        int span;
        int tick;
        hold_left = 0;
        mode = 0;
        span = 0;
        tick = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_polar
        jtp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_polar.size() == 0) begin
                want = '0;
                note_error("output word with nothing pending", want, m_data);
            end else begin
                want = pending_polar.pop_front();
                if (m_data.heading !== want.heading || m_data.strength !== want.strength)
                    note_error("polar mismatch", want, m_data);
            end
        end
    end

    initial begin : stimulus
        jtp_in_t  w;
        jtp_out_t want;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (sample_table[i]) begin
            w.x_position = sample_table[i].x;
            w.y_position = sample_table[i].y;
            if (sample_table[i].fixed) begin
                want.heading  = sample_table[i].heading;
                want.strength = sample_table[i].strength;
            end else begin
                want = polar_of(w);
            end
            send_sample(w, want);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // long output hold-off while input keeps coming: fills the pipe
            if (n == 0 || n == 650)
                hold_req = 1'b1;
            // sender pauses until the pipe has drained
            if (n == 400 || n == 850) begin
                s_valid <= 1'b0;
                while (pending_polar.size() != 0)
                    @(negedge aclk);
                @(negedge aclk);
            end
            w = random_sample();
            send_sample(w, polar_of(w));
        end
        s_valid <= 1'b0;

        while (pending_polar.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("tb_joystick_to_polar: done, clean");
        else
            $display("tb_joystick_to_polar: done, errors");
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("tb_joystick_to_polar: done, errors");
        $finish;
    end

endmodule
